// ===== rtl/erip_pkg.sv =====
// ----------------------------------------------------------------------------
// erip_pkg
// Shared constants and types for the eased ramp interpolator: field widths,
// command and register codes, result kinds and the controller/datapath links.
// ----------------------------------------------------------------------------
package erip_pkg;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int FRAME_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Default number of fraction bits of the ramp position t
    localparam int FRACTION_BITS_DEF = 16;

    // Item commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_END_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE    = 2'd2;

    // Ease modes
    localparam logic EASE_LINEAR = 1'b0;
    localparam logic EASE_SQRT   = 1'b1;

    // What the output item carries
    typedef enum logic [1:0] {
        RES_BLANK    = 2'd0,   // all fields zero
        RES_FIN_ONLY = 2'd1,   // no value, finished set
        RES_VALUE    = 2'd2    // interpolated value, finished from the count
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_start;
        logic      load_tick;
        logic      div_step;
        logic      sqrt_step;
        logic      mul;
        logic      sum;
        logic      out_load;
        res_kind_t out_kind;
    } erip_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fin;
        logic over;
        logic ease;
        logic div_last;
        logic sqrt_last;
        logic out_free;
    } erip_status_t;

endpackage

// ===== rtl/erip_ifs.sv =====
// ----------------------------------------------------------------------------
// erip_ifs
// Valid/ready channels of the eased ramp interpolator: command items,
// result items and configuration writes.
// ----------------------------------------------------------------------------

// Command item channel
interface erip_cmd_if import erip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] current_value;

    modport source (output valid, output command, output current_value, input ready);
    modport sink   (input valid, input command, input current_value, output ready);
endinterface

// Result item channel
interface erip_res_if import erip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              value_valid;
    logic [DATA_W-1:0] ramp_value;
    logic              finished;

    modport source (output valid, output value_valid, output ramp_value, output finished,
                    input ready);
    modport sink   (input valid, input value_valid, input ramp_value, input finished,
                    output ready);
endinterface

// Configuration write channel
interface erip_cfg_if import erip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/eased_ramp_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// eased_ramp_interpolator_core
// Ramp generator moving a signed 20.12 value from a captured start to a
// configured end over a set number of ticks, linear or square-root eased.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch  carries one item per command: start (captures current_value and
//           restarts the frame count) or tick (advances one frame while a ramp runs).
//   res_ch  returns exactly one item per command item: value_valid,
//           ramp_value and finished.
//   cfg_ch  writes end_frames (index 0), end_distance (1) and ease_mode (2);
//           it is always ready; write it only while the block is idle (not enforced).
// Sequencing:
//   A start item or a tick outside a running ramp goes straight to the output
//   register; a tick past the end of an eased ramp passes the divide state first.
//   A running tick passes the bit-serial divider and, in eased mode, the square
//   root, one bit per cycle each, then the multiply and the add, and is then
//   loaded into the output register; the next item is accepted after that load.
//   One item is in work at a time, and the output register holds one result.
// Reset: configuration returns to one frame, zero distance, linear mode; the
//   ramp waits for a start. When the receiver stalls, the result holds in the
//   output register; a next item is still taken, and its result waits.
// ----------------------------------------------------------------------------
module eased_ramp_interpolator_core import erip_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    erip_cmd_if.sink    cmd_ch,
    erip_res_if.source  res_ch,
    erip_cfg_if.sink    cfg_ch
);

    erip_cmd_t    cmd;
    erip_status_t status;

    // Configuration is taken at any time
    assign cfg_ch.ready = 1'b1;

    // Sequencer
    erip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .command  (cmd_ch.command),
        .in_ready (cmd_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state
    erip_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_ch.valid),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .current_value (cmd_ch.current_value),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (res_ch.ready),
        .out_valid     (res_ch.valid),
        .value_valid   (res_ch.value_valid),
        .ramp_value    (res_ch.ramp_value),
        .finished      (res_ch.finished)
    );

endmodule

// ===== rtl/erip_datapath.sv =====
// ----------------------------------------------------------------------------
// erip_datapath
// Configuration registers, ramp state, serial divider (count / frames),
// serial square root, multiplier, final add and the output register.
// ----------------------------------------------------------------------------
module erip_datapath import erip_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic [DATA_W-1:0]    current_value,
    input  erip_cmd_t            cmd,
    output erip_status_t         status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 value_valid,
    output logic [DATA_W-1:0]    ramp_value,
    output logic                 finished
);

    localparam int F      = FRACTION_BITS;
    localparam int TW     = F + 1;            // t in [0, 1] at F fraction bits
    localparam int STEP_W = $clog2(F + 1);
    localparam int XW     = 2 * F + 2;        // sqrt operand, padded to even width
    localparam int RW     = F + 4;            // sqrt partial remainder
    localparam int PW     = DATA_W + TW;      // product width

    // Configuration
    logic [FRAME_W-1:0] end_frames_reg;
    logic [DATA_W-1:0]  end_distance_reg;
    logic               ease_mode_reg;

    // Ramp state
    logic [DATA_W-1:0]  start_value_reg;
    logic [FRAME_W-1:0] frame_count_reg;
    logic               fin_reg;
    logic               over_reg;
    logic [DATA_W-1:0]  mag_reg;
    logic               neg_reg;

    // Iteration units
    logic [STEP_W-1:0]  step_reg;
    logic [FRAME_W-1:0] rem_reg;
    logic [TW-1:0]      quot_reg;
    logic [XW-1:0]      sq_x_reg;
    logic [RW-1:0]      sq_rem_reg;
    logic [TW-1:0]      root_reg;
    logic [PW-1:0]      prod_reg;
    logic [DATA_W-1:0]  sum_reg;

    // Output register
    logic               out_valid_reg;
    logic               value_valid_reg;
    logic [DATA_W-1:0]  ramp_value_reg;
    logic               finished_reg;

    // Combinational
    logic [FRAME_W-1:0] n_eff;
    logic [FRAME_W-1:0] cnt_inc;
    logic [FRAME_W-1:0] cnt_clamp;
    logic [DATA_W:0]    diff;
    logic [DATA_W:0]    diff_neg;
    logic               step_last;
    logic               step_first;
    logic [FRAME_W:0]   div_sh;
    logic               div_ge;
    logic [FRAME_W:0]   div_sub;
    logic [XW-1:0]      sq_src;
    logic [1:0]         sq_pair;
    logic [RW-1:0]      sq_rem_base;
    logic [TW-1:0]      sq_root_base;
    logic [RW-1:0]      sq_rem_ext;
    logic [RW-1:0]      sq_trial;
    logic               sq_ge;
    logic [TW-1:0]      t_sel;
    logic [DATA_W-1:0]  part;

    // Ramp length of zero behaves as one
    assign n_eff     = (end_frames_reg == '0) ? FRAME_W'(1) : end_frames_reg;
    assign cnt_inc   = frame_count_reg + FRAME_W'(1);
    assign cnt_clamp = (cnt_inc > n_eff) ? n_eff : cnt_inc;

    // Signed distance left to travel, as sign and magnitude
    assign diff     = {end_distance_reg[DATA_W-1], end_distance_reg}
                    - {start_value_reg[DATA_W-1], start_value_reg};
    assign diff_neg = ~diff + (DATA_W+1)'(1);

    assign step_last  = (step_reg == STEP_W'(F));
    assign step_first = (step_reg == '0);

    // Divider step: first step compares the count itself, later ones shift
    assign div_sh  = step_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign div_ge  = (div_sh >= {1'b0, n_eff});
    assign div_sub = div_sh - {1'b0, n_eff};

    // Square root step: bring in two operand bits, try root*4+1
    assign sq_src       = step_first ? {1'b0, quot_reg, {F{1'b0}}} : sq_x_reg;
    assign sq_pair      = sq_src[XW-1 -: 2];
    assign sq_rem_base  = step_first ? '0 : sq_rem_reg;
    assign sq_root_base = step_first ? '0 : root_reg;
    assign sq_rem_ext   = {sq_rem_base[RW-3:0], sq_pair};
    assign sq_trial     = {1'b0, sq_root_base, 2'b01};
    assign sq_ge        = (sq_rem_ext >= sq_trial);

    assign t_sel = (ease_mode_reg == EASE_SQRT) ? root_reg : quot_reg;
    assign part  = prod_reg[F +: DATA_W];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_frames_reg   <= FRAME_W'(1);
            end_distance_reg <= '0;
            ease_mode_reg    <= EASE_LINEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_END_FRAMES:   end_frames_reg   <= cfg_data[FRAME_W-1:0];
                REG_END_DISTANCE: end_distance_reg <= cfg_data;
                REG_EASE_MODE:    ease_mode_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Capture start value, advance the frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= '0;
            frame_count_reg <= '0;
        end
        else if (cmd.load_start)
        begin
            start_value_reg <= current_value;
            frame_count_reg <= '0;
        end
        else if (cmd.load_tick)
        begin
            frame_count_reg <= cnt_inc;
        end
    end

    // Latch per-tick flags and operands
    always_ff @(posedge clk)
    begin
        if (cmd.load_tick)
        begin
            fin_reg  <= (cnt_inc >= n_eff);
            over_reg <= (cnt_inc > n_eff);
            neg_reg  <= diff[DATA_W];
            mag_reg  <= diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
        end
    end

    // Step counter shared by divider and square root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.load_tick)
            step_reg <= '0;
        else if (cmd.div_step || cmd.sqrt_step)
            step_reg <= step_last ? '0 : step_reg + STEP_W'(1);
    end

    // Divider: one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_tick)
            rem_reg <= cnt_clamp;
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? div_sub[FRAME_W-1:0] : div_sh[FRAME_W-1:0];
            quot_reg <= {quot_reg[TW-2:0], div_ge};
        end
    end

    // Square root: one root bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_step)
        begin
            sq_x_reg   <= {sq_src[XW-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_rem_ext - sq_trial) : sq_rem_ext;
            root_reg   <= {sq_root_base[TW-2:0], sq_ge};
        end
    end

    // Scale distance by t, then add to start
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= PW'(mag_reg) * PW'(t_sel);
        if (cmd.sum)
            sum_reg <= neg_reg ? (start_value_reg - part) : (start_value_reg + part);
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_kind)
                RES_VALUE:
                begin
                    value_valid_reg <= 1'b1;
                    ramp_value_reg  <= sum_reg;
                    finished_reg    <= fin_reg;
                end
                RES_FIN_ONLY:
                begin
                    value_valid_reg <= 1'b0;
                    ramp_value_reg  <= '0;
                    finished_reg    <= 1'b1;
                end
                default:
                begin
                    value_valid_reg <= 1'b0;
                    ramp_value_reg  <= '0;
                    finished_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_valid = value_valid_reg;
    assign ramp_value  = ramp_value_reg;
    assign finished    = finished_reg;

    // Report to controller
    assign status.fin       = fin_reg;
    assign status.over      = over_reg;
    assign status.ease      = (ease_mode_reg == EASE_SQRT);
    assign status.div_last  = step_last;
    assign status.sqrt_last = step_last;
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== rtl/erip_ctrl.sv =====
// ----------------------------------------------------------------------------
// erip_ctrl
// Sequencer of the eased ramp interpolator: ramp phase, item intake and the
// order of divide, square root, multiply, add and output load.
// ----------------------------------------------------------------------------
module erip_ctrl import erip_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         command,
    output logic         in_ready,
    input  erip_status_t status,
    output erip_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SQRT = 6'b000100,
        S_MUL  = 6'b001000,
        S_SUM  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        P_WAIT = 3'b001,   // awaiting start
        P_RUN  = 3'b010,
        P_DONE = 3'b100
    } phase_t;

    state_t    state_reg, state_next;
    phase_t    phase_reg, phase_next;
    res_kind_t kind_reg,  kind_next;

    // Advance state, phase and pending result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_WAIT;
            kind_reg  <= RES_BLANK;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
        end
    end

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_START)
                    begin
                        cmd.load_start = 1'b1;
                        phase_next     = P_RUN;
                        kind_next      = RES_BLANK;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            P_RUN:
                            begin
                                cmd.load_tick = 1'b1;
                                state_next    = S_DIV;
                            end
                            P_DONE:
                            begin
                                kind_next  = RES_FIN_ONLY;
                                state_next = S_OUT;
                            end
                            default:
                            begin
                                kind_next  = RES_BLANK;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                end
            end

            S_DIV:
            begin
                if (status.fin)
                    phase_next = P_DONE;
                // Count past the ramp length in eased mode: no value
                if (status.over && status.ease)
                begin
                    kind_next  = RES_FIN_ONLY;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                        state_next = status.ease ? S_SQRT : S_MUL;
                end
            end

            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                    state_next = S_MUL;
            end

            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end

            S_SUM:
            begin
                cmd.sum    = 1'b1;
                kind_next  = RES_VALUE;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kind_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
